@@ hw/rtl/i2csib_pkg.sv @@
// Package for the I2C sensor init and burst read sequencer
// Holds the bus phase encoding and the configuration register indexes
// No dependencies
`timescale 1ns / 1ps

package i2csib_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INIT_REPEAT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INIT_FILL = 2'd2;

  // register reset values
  localparam logic [6:0] DEV_ADDR_RST = 7'd53;
  localparam logic [3:0] INIT_REPEAT_RST = 4'd2;
  localparam logic [7:0] INIT_FILL_RST = 8'h00;

  // request widths
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 16;

  // bus phase, one-hot
  typedef enum logic [13:0] {
    PH_IDLE      = 14'b00000000000001,
    PH_START_A   = 14'b00000000000010,
    PH_START_B   = 14'b00000000000100,
    PH_WR_LOW    = 14'b00000000001000,
    PH_WR_HIGH   = 14'b00000000010000,
    PH_SACK_LOW  = 14'b00000000100000,
    PH_SACK_HIGH = 14'b00000001000000,
    PH_RD_LOW    = 14'b00000010000000,
    PH_RD_HIGH   = 14'b00000100000000,
    PH_MACK_LOW  = 14'b00001000000000,
    PH_MACK_HIGH = 14'b00010000000000,
    PH_STOP_A    = 14'b00100000000000,
    PH_STOP_B    = 14'b01000000000000,
    PH_STOP_C    = 14'b10000000000000
  } phase_e;

endpackage

@@ hw/rtl/i2c_sensor_init_and_burst_read.sv @@
// Top level of the I2C sensor init and burst read sequencer
// Depends on i2csib_pkg for the phase encoding and register indexes
`timescale 1ns / 1ps

// Bit-level I2C master stepped by one request per bus tick: each input request
// carries the data-ready event and the sampled SDA level, and yields exactly one
// output request with the SCL/SDA levels for that tick, any completed read byte
// and status. A bit spans two ticks (SCL low, then SCL high). Until init_repeat
// write runs (address, INIT_BYTES fill bytes) have been sent, each event runs a
// write; afterwards each event runs a READ_BYTES burst read, byte_last marking
// the final byte (tlast). Throughput is one request per clock: the sequencer
// state advances in the accepting cycle and the result lands in an output
// register, so input is taken whenever that register is empty or being drained.
// The result is valid in the cycle after the input is accepted.
module i2c_sensor_init_and_burst_read #(
  parameter int unsigned READ_BYTES = 4,
  parameter int unsigned INIT_BYTES = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [i2csib_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [i2csib_pkg::CfgDataW-1:0]  cfg_data_i,
  // input ticks
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] data_ready, [1] sda_in, [7:2] zero
  input  logic [i2csib_pkg::InDataW-1:0]   s_axis_tdata,
  // result ticks
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] scl_level, [1] sda_drive, [2] sda_level, [3] byte_valid,
  // [11:4] byte_data, [13:12] byte_index, [14] init_done, [15] busy_res
  output logic [i2csib_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast  // byte_last
);
  import i2csib_pkg::*;

  localparam int unsigned MaxBytes = (READ_BYTES > INIT_BYTES) ? READ_BYTES : INIT_BYTES;
  localparam int unsigned CntRaw = $clog2(MaxBytes + 1);
  localparam int unsigned CntW = (CntRaw < 2) ? 2 : CntRaw;
  localparam logic [CntW-1:0] InitBytesC = CntW'(INIT_BYTES);
  localparam logic [CntW-1:0] ReadBytesC = CntW'(READ_BYTES);

  // configuration registers
  logic [6:0] dev_addr_q;
  logic [3:0] init_repeat_q;
  logic [7:0] init_fill_q;

  // sequencer state
  phase_e          phase_q, phase_d;
  logic [3:0]      bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]      shift_q, shift_d;
  logic [3:0]      init_runs_q, init_runs_d;
  logic            init_flag_q, init_flag_d;
  logic            pending_q, pending_d;
  logic            sda_out_q, sda_out_d;
  logic            reading_q, reading_d;

  // output register
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic                m_last_q, m_last_d;

  // per-tick results
  logic       scl, drive, level, level_out;
  logic       valid, last;
  logic [7:0] data;
  logic [1:0] idx;
  logic       busy;
  logic       accept;
  logic       data_ready, sda_in;
  logic [3:0] bit_inc;
  logic [CntW-1:0] byte_inc;
  logic       last_byte;

  assign data_ready = s_axis_tdata[0];
  assign sda_in     = s_axis_tdata[1];

  // handshake: take a tick when the result register frees up
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign bit_inc   = bit_cnt_q + 4'd1;
  assign byte_inc  = byte_cnt_q + CntW'(1);
  assign last_byte = (byte_inc >= ReadBytesC);
  assign busy      = (phase_q != PH_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RST;
      init_repeat_q <= INIT_REPEAT_RST;
      init_fill_q   <= INIT_FILL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEV_ADDR:    dev_addr_q    <= cfg_data_i[6:0];
        REG_INIT_REPEAT: init_repeat_q <= cfg_data_i[3:0];
        REG_INIT_FILL:   init_fill_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // phase sequencer and line levels for one tick
  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    byte_cnt_d  = byte_cnt_q;
    shift_d     = shift_q;
    init_runs_d = init_runs_q;
    init_flag_d = init_flag_q;
    pending_d   = pending_q || data_ready;
    reading_d   = reading_q;
    scl   = 1'b1;
    drive = 1'b1;
    level = 1'b1;
    valid = 1'b0;
    data  = 8'h00;
    idx   = 2'd0;
    last  = 1'b0;

    case (phase_q)
      PH_START_A: begin
        level   = 1'b0;
        phase_d = PH_START_B;
      end
      PH_START_B: begin
        scl        = 1'b0;
        level      = 1'b0;
        reading_d  = init_flag_q;
        shift_d    = {dev_addr_q, init_flag_q};
        bit_cnt_d  = 4'd0;
        byte_cnt_d = '0;
        phase_d    = PH_WR_LOW;
      end
      PH_WR_LOW: begin
        scl     = 1'b0;
        level   = shift_q[7];
        phase_d = PH_WR_HIGH;
      end
      PH_WR_HIGH: begin
        level     = sda_out_q;
        shift_d   = {shift_q[6:0], 1'b0};
        bit_cnt_d = bit_inc;
        phase_d   = bit_inc[3] ? PH_SACK_LOW : PH_WR_LOW;
      end
      PH_SACK_LOW: begin
        scl     = 1'b0;
        drive   = 1'b0;
        phase_d = PH_SACK_HIGH;
      end
      PH_SACK_HIGH: begin
        drive     = 1'b0;
        bit_cnt_d = 4'd0;
        if (reading_q) begin
          byte_cnt_d = '0;
          shift_d    = 8'h00;
          phase_d    = PH_RD_LOW;
        end else if (byte_cnt_q < InitBytesC) begin
          byte_cnt_d = byte_inc;
          shift_d    = init_fill_q;
          phase_d    = PH_WR_LOW;
        end else begin
          phase_d = PH_STOP_A;
        end
      end
      PH_RD_LOW: begin
        scl     = 1'b0;
        drive   = 1'b0;
        phase_d = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        drive     = 1'b0;
        shift_d   = {shift_q[6:0], sda_in};
        bit_cnt_d = bit_inc;
        if (bit_inc[3]) begin
          valid   = 1'b1;
          data    = {shift_q[6:0], sda_in};
          idx     = byte_cnt_q[1:0];
          last    = last_byte;
          phase_d = PH_MACK_LOW;
        end else begin
          phase_d = PH_RD_LOW;
        end
      end
      PH_MACK_LOW: begin
        scl     = 1'b0;
        level   = 1'b0;
        phase_d = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        level     = 1'b0;
        bit_cnt_d = 4'd0;
        if (last_byte) begin
          phase_d = PH_STOP_A;
        end else begin
          byte_cnt_d = byte_inc;
          shift_d    = 8'h00;
          phase_d    = PH_RD_LOW;
        end
      end
      PH_STOP_A: begin
        scl     = 1'b0;
        level   = 1'b0;
        phase_d = PH_STOP_B;
      end
      PH_STOP_B: begin
        level   = 1'b0;
        phase_d = PH_STOP_C;
      end
      PH_STOP_C: begin
        // count finished init runs, saturating
        if (!reading_q && !init_flag_q) begin
          init_runs_d = (init_runs_q != 4'hF) ? init_runs_q + 4'd1 : init_runs_q;
          if (init_runs_d >= init_repeat_q) begin
            init_flag_d = 1'b1;
          end
        end
        phase_d = PH_IDLE;
      end
      default: begin
        // idle: start on a latched event
        phase_d = PH_IDLE;
        if (pending_d) begin
          pending_d = 1'b0;
          phase_d   = PH_START_A;
        end
      end
    endcase

    sda_out_d = drive ? level : sda_out_q;
    level_out = drive ? level : 1'b1;
  end

  // pack the result
  always_comb begin
    m_data_d = {busy, init_flag_d, idx, data, valid, level_out, drive, scl};
    m_last_d = last;
  end

  // sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= 4'd0;
      byte_cnt_q  <= '0;
      shift_q     <= 8'h00;
      init_runs_q <= 4'd0;
      init_flag_q <= 1'b0;
      pending_q   <= 1'b0;
      sda_out_q   <= 1'b1;
      reading_q   <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      byte_cnt_q  <= byte_cnt_d;
      shift_q     <= shift_d;
      init_runs_q <= init_runs_d;
      init_flag_q <= init_flag_d;
      pending_q   <= pending_d;
      sda_out_q   <= sda_out_d;
      reading_q   <= reading_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= s_axis_tvalid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
      m_last_q <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  // a received byte only appears inside a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[3] |-> m_data_q[15])
    else $error("byte reported outside a transaction");

  // a released data line reads back high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_data_q[1] |-> m_data_q[2])
    else $error("released sda shows low level");

  // the last-byte flag comes only with a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_last_q |-> m_data_q[3])
    else $error("last flag without received byte");

  // initialization, once done, stays done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_flag_q |=> init_flag_q)
    else $error("init flag dropped");

  // reads only start after initialization
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reading_q |-> init_flag_q)
    else $error("read transaction before init done");
`endif

endmodule
